@@ hdl/fd_pkg.sv @@
// ----------------------------------------------------------------------------
// fd_pkg
// Types and constants shared by the fall detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fd_pkg;

    localparam int AXIS_W    = 16;
    localparam int MAG_W     = 32;
    localparam int SAMPLES_W = 8;
    localparam int CFG_IDX_W = 3;

    // Depth of the queue between classification and state update.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values.
    localparam logic [MAG_W-1:0]     FREEFALL_LIMIT_RST = 32'd9000000;
    localparam logic [MAG_W-1:0]     IMPACT_LIMIT_RST   = 32'd1677721600;
    localparam logic [MAG_W-1:0]     STILL_LIMIT_RST    = 32'd42250000;
    localparam logic [SAMPLES_W-1:0] FREEFALL_MIN_RST   = 8'd2;
    localparam logic [SAMPLES_W-1:0] STILL_SAMPLES_RST  = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREEFALL_LIMIT = 3'd0,
        CFG_IMPACT_LIMIT   = 3'd1,
        CFG_STILL_LIMIT    = 3'd2,
        CFG_FREEFALL_MIN   = 3'd3,
        CFG_STILL_SAMPLES  = 3'd4
    } fd_cfg_idx_t;

    // Thresholds used by the classifier.
    typedef struct packed {
        logic [MAG_W-1:0] freefall_limit_sq;
        logic [MAG_W-1:0] impact_limit_sq;
        logic [MAG_W-1:0] still_limit_sq;
    } fd_limits_t;

    // Sample counts used by the state update.
    typedef struct packed {
        logic [SAMPLES_W-1:0] freefall_min_samples;
        logic [SAMPLES_W-1:0] still_samples;
    } fd_counts_t;

    // One classified sample as it travels through the queue.
    typedef struct packed {
        logic [MAG_W-1:0] magnitude_sq;
        logic             below_freefall;
        logic             above_impact;
        logic             below_still;
    } fd_item_t;

endpackage

`default_nettype wire

@@ hdl/fd_front.sv @@
// ----------------------------------------------------------------------------
// fd_front
// Accepts samples, squares the three axes, sums them and classifies the
// squared magnitude against the three thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module fd_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [fd_pkg::AXIS_W-1:0] accel_x,
    input  wire logic signed [fd_pkg::AXIS_W-1:0] accel_y,
    input  wire logic signed [fd_pkg::AXIS_W-1:0] accel_z,
    input  wire fd_pkg::fd_limits_t           limits,
    output logic                              item_valid,
    input  wire logic                         item_ready,
    output fd_pkg::fd_item_t                  item
);
    import fd_pkg::*;

    localparam int ABS_W  = AXIS_W + 1;
    localparam int PROD_W = 2 * ABS_W;

    function automatic logic [MAG_W-1:0] square_axis(input logic [AXIS_W-1:0] raw);
        logic [ABS_W-1:0]  ext;
        logic [ABS_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        ext  = {raw[AXIS_W-1], raw};
        mag  = raw[AXIS_W-1] ? (ABS_W'(0) - ext) : ext;
        prod = PROD_W'(mag) * PROD_W'(mag);
        // The largest square is 2^30, so the low bits carry it all.
        return prod[MAG_W-1:0];
    endfunction

    logic             sq_valid_reg;
    logic [MAG_W-1:0] sq_x_reg;
    logic [MAG_W-1:0] sq_y_reg;
    logic [MAG_W-1:0] sq_z_reg;
    logic             sum_valid_reg;
    logic [MAG_W-1:0] sum_reg;
    logic             sum_load;
    logic             sq_load;
    logic             sq_move;

    // The sum stage takes a new value when it is empty or being drained.
    assign sum_load = !sum_valid_reg || item_ready;
    assign sq_move  = sq_valid_reg && sum_load;
    assign in_ready = !sq_valid_reg || sum_load;
    assign sq_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sq_valid_reg <= in_valid;
            end
            if (sum_load)
            begin
                sum_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_load)
        begin
            sq_x_reg <= square_axis(accel_x);
            sq_y_reg <= square_axis(accel_y);
            sq_z_reg <= square_axis(accel_z);
        end
        if (sq_move)
        begin
            sum_reg <= sq_x_reg + sq_y_reg + sq_z_reg;
        end
    end

    assign item_valid = sum_valid_reg;

    always_comb
    begin
        item.magnitude_sq   = sum_reg;
        item.below_freefall = sum_reg < limits.freefall_limit_sq;
        item.above_impact   = sum_reg > limits.impact_limit_sq;
        item.below_still    = sum_reg < limits.still_limit_sq;
    end

endmodule

`default_nettype wire

@@ hdl/fd_queue.sv @@
// ----------------------------------------------------------------------------
// fd_queue
// Short first-in first-out queue of classified samples between the front
// and the back of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

module fd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire fd_pkg::fd_item_t push_item,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output fd_pkg::fd_item_t      pop_item
);
    import fd_pkg::*;

    fd_item_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fd_back.sv @@
// ----------------------------------------------------------------------------
// fd_back
// Runs the free fall, impact and stillness tracking on classified samples
// and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fd_back #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire fd_pkg::fd_item_t item,
    input  wire fd_pkg::fd_counts_t counts,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [fd_pkg::MAG_W-1:0] magnitude_sq,
    output logic                  freefall_event,
    output logic                  impact_after_freefall,
    output logic                  impact_alone,
    output logic                  fall_confirmed
);
    import fd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > SAMPLES_W) ? COUNT_WIDTH : SAMPLES_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] low_run_reg;
    logic [COUNT_WIDTH-1:0] low_run_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic                   reported_reg;
    logic                   reported_next;
    logic                   active_reg;
    logic                   active_next;
    logic [COUNT_WIDTH-1:0] quiet_reg;
    logic [COUNT_WIDTH-1:0] quiet_next;
    logic                   out_valid_reg;
    logic [MAG_W-1:0]       magnitude_reg;
    logic                   ff_event_reg;
    logic                   ff_event_next;
    logic                   imp_ff_reg;
    logic                   imp_ff_next;
    logic                   imp_alone_reg;
    logic                   imp_alone_next;
    logic                   confirmed_reg;
    logic                   confirmed_next;
    logic [COUNT_WIDTH-1:0] low_run_inc;
    logic [COUNT_WIDTH-1:0] quiet_inc;
    logic                   run_reached;
    logic                   quiet_reached;
    logic                   pop;

    assign item_ready = !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;

    assign low_run_inc   = (low_run_reg == COUNT_MAX) ? low_run_reg
                                                      : low_run_reg + COUNT_WIDTH'(1);
    assign quiet_inc     = (quiet_reg == COUNT_MAX) ? quiet_reg
                                                    : quiet_reg + COUNT_WIDTH'(1);
    assign run_reached   = CMP_W'(low_run_inc) >= CMP_W'(counts.freefall_min_samples);
    assign quiet_reached = CMP_W'(quiet_inc) >= CMP_W'(counts.still_samples);

    always_comb
    begin
        low_run_next   = '0;
        armed_next     = armed_reg;
        reported_next  = reported_reg;
        active_next    = active_reg;
        quiet_next     = quiet_reg;
        ff_event_next  = 1'b0;
        imp_ff_next    = 1'b0;
        imp_alone_next = 1'b0;
        confirmed_next = 1'b0;

        if (item.below_freefall)
        begin
            low_run_next = low_run_inc;
            if (run_reached)
            begin
                armed_next = 1'b1;
                if (!reported_reg)
                begin
                    reported_next = 1'b1;
                    ff_event_next = 1'b1;
                end
            end
        end

        // An impact already under way is judged for stillness; the sample
        // that starts an impact is not.
        if (active_reg)
        begin
            if (item.below_still)
            begin
                if (quiet_reached)
                begin
                    active_next    = 1'b0;
                    quiet_next     = '0;
                    armed_next     = 1'b0;
                    confirmed_next = 1'b1;
                end
                else
                begin
                    quiet_next = quiet_inc;
                end
            end
            else
            begin
                active_next   = 1'b0;
                quiet_next    = '0;
                armed_next    = 1'b0;
                reported_next = 1'b0;
            end
        end
        else if (item.above_impact)
        begin
            active_next    = 1'b1;
            quiet_next     = '0;
            reported_next  = 1'b0;
            imp_ff_next    = armed_next;
            imp_alone_next = !armed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_run_reg   <= '0;
            armed_reg     <= 1'b0;
            reported_reg  <= 1'b0;
            active_reg    <= 1'b0;
            quiet_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                low_run_reg  <= low_run_next;
                armed_reg    <= armed_next;
                reported_reg <= reported_next;
                active_reg   <= active_next;
                quiet_reg    <= quiet_next;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            magnitude_reg <= item.magnitude_sq;
            ff_event_reg  <= ff_event_next;
            imp_ff_reg    <= imp_ff_next;
            imp_alone_reg <= imp_alone_next;
            confirmed_reg <= confirmed_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign magnitude_sq          = magnitude_reg;
    assign freefall_event        = ff_event_reg;
    assign impact_after_freefall = imp_ff_reg;
    assign impact_alone          = imp_alone_reg;
    assign fall_confirmed        = confirmed_reg;

endmodule

`default_nettype wire

@@ hdl/fall_detector.sv @@
// ----------------------------------------------------------------------------
// fall_detector
// Free fall, impact and stillness fall detector for 3-axis accelerometer
// samples, with a register file for its thresholds and sample counts.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------
//  in        in_valid/in_ready     accel_x, accel_y, accel_z
//  out       out_valid/out_ready   magnitude_sq, freefall_event,
//                                  impact_after_freefall, impact_alone,
//                                  fall_confirmed
//  cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  One transaction per cycle each way when nothing stalls. The squares are
//  registered at the accepting edge, and the result then passes through the
//  sum register, the queue and the output register.
//  Reset clears the tracking state and loads the register defaults; samples
//  are taken right after reset. A stalled output fills the queue first and
//  then holds the input side. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fall_detector #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [fd_pkg::AXIS_W-1:0]     accel_x,
    input  wire logic signed [fd_pkg::AXIS_W-1:0]     accel_y,
    input  wire logic signed [fd_pkg::AXIS_W-1:0]     accel_z,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [fd_pkg::MAG_W-1:0]                  magnitude_sq,
    output logic                                      freefall_event,
    output logic                                      impact_after_freefall,
    output logic                                      impact_alone,
    output logic                                      fall_confirmed,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [fd_pkg::MAG_W-1:0]             cfg_data
);
    import fd_pkg::*;

    fd_limits_t limits_reg;
    fd_counts_t counts_reg;
    logic       cfg_write;
    logic       q_push_valid;
    logic       q_push_ready;
    fd_item_t   q_push_item;
    logic       q_pop_valid;
    logic       q_pop_ready;
    fd_item_t   q_pop_item;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.freefall_limit_sq    <= FREEFALL_LIMIT_RST;
            limits_reg.impact_limit_sq      <= IMPACT_LIMIT_RST;
            limits_reg.still_limit_sq       <= STILL_LIMIT_RST;
            counts_reg.freefall_min_samples <= FREEFALL_MIN_RST;
            counts_reg.still_samples        <= STILL_SAMPLES_RST;
        end
        else if (cfg_write)
        begin
            // Writes beyond the register list are dropped.
            unique case (cfg_index)
                CFG_FREEFALL_LIMIT: limits_reg.freefall_limit_sq <= cfg_data;
                CFG_IMPACT_LIMIT:   limits_reg.impact_limit_sq   <= cfg_data;
                CFG_STILL_LIMIT:    limits_reg.still_limit_sq    <= cfg_data;
                CFG_FREEFALL_MIN:
                    counts_reg.freefall_min_samples <= cfg_data[SAMPLES_W-1:0];
                CFG_STILL_SAMPLES:
                    counts_reg.still_samples <= cfg_data[SAMPLES_W-1:0];
                default: ;
            endcase
        end
    end

    fd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .limits     (limits_reg),
        .item_valid (q_push_valid),
        .item_ready (q_push_ready),
        .item       (q_push_item)
    );

    fd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    fd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .item_valid            (q_pop_valid),
        .item_ready            (q_pop_ready),
        .item                  (q_pop_item),
        .counts                (counts_reg),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .magnitude_sq          (magnitude_sq),
        .freefall_event        (freefall_event),
        .impact_after_freefall (impact_after_freefall),
        .impact_alone          (impact_alone),
        .fall_confirmed        (fall_confirmed)
    );

endmodule

`default_nettype wire
